>>> rtl/lfd_pkg.sv
// Package for the LED fade ramp dimmer: widths, command codes, register
// indexes, reset values, pipeline structs and the exponent table.
// No dependencies; every other file of the block uses it.
`timescale 1ns / 1ps
`default_nettype none

package lfd_pkg;

  // Field widths
  localparam int unsigned LEVEL_W = 10;
  localparam int unsigned DUTY_W  = 11;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned CFG_IDX_W = 2;

  // Ramp range
  localparam int unsigned FULL_SCALE = 1000;
  localparam int unsigned EXP_MAX_LEVEL = 1000;

  // Command codes
  localparam logic [KIND_W-1:0] KIND_TICK = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SET  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ON   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_OFF  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NOW  = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL = 2'd2;

  // Reset values
  localparam logic [LEVEL_W-1:0] RAMP_STEP_RESET  = 10'd10;
  localparam logic [LEVEL_W-1:0] MIN_LEVEL_RESET  = 10'd0;
  localparam logic [LEVEL_W-1:0] MAX_LEVEL_RESET  = 10'd1000;
  localparam logic [LEVEL_W-1:0] REMEMBERED_RESET = 10'd700;

  // Division by FULL_SCALE: ceiling reciprocal in Q30. The error term is
  // small enough that the floor is exact for products up to 1000*1000.
  localparam int unsigned DIV_SHIFT = 30;
  localparam int unsigned DIV_RECIP_W = 21;
  localparam logic [DIV_RECIP_W-1:0] DIV_RECIP =
    DIV_RECIP_W'(((1 << DIV_SHIFT) + FULL_SCALE - 1) / FULL_SCALE);

  // v / 100 for v in 0..1000 as (v * 41) >> 12, exact over that range
  localparam int unsigned DEC_MUL = 41;
  localparam int unsigned DEC_SHIFT = 12;
  localparam int unsigned EXP_STEPS = 100;

  // Exponent table: 2^(r/100) in Q30, built with the same rounded steps
  localparam logic [63:0] EXP_ONE_Q30  = 64'd1073741824;
  localparam logic [63:0] EXP_STEP_Q30 = 64'd1081210289;
  localparam logic [63:0] EXP_ROUND    = 64'd536870912;

  typedef logic [30:0] exp_tab_t [0:EXP_STEPS-1];

  function automatic exp_tab_t exp_tab_build();
    exp_tab_t tab;
    logic [63:0] p;
    p = EXP_ONE_Q30;
    for (int i = 0; i < EXP_STEPS; i++) begin
      tab[i] = p[30:0];
      p = (p * EXP_STEP_Q30 + EXP_ROUND) >> 30;
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = exp_tab_build();

  // Item status carried down the pipeline
  typedef struct packed {
    logic               written;
    logic               is_tick;
    logic [LEVEL_W-1:0] level;
    logic               lamp_on;
  } item_t;

  // Item plus its exponent level
  typedef struct packed {
    item_t              item;
    logic [LEVEL_W-1:0] v;
  } map_t;

endpackage

`default_nettype wire

>>> rtl/lfd_if.sv
// Valid/ready channel interfaces for the dimmer: command items in,
// result items out. Depends on lfd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface lfd_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [lfd_pkg::KIND_W-1:0]   kind;
  logic [lfd_pkg::LEVEL_W-1:0]  target_level;

  modport source (output valid, kind, target_level, input ready);
  modport sink   (input valid, kind, target_level, output ready);
endinterface

interface lfd_res_if;
  logic                         valid;
  logic                         ready;
  logic [lfd_pkg::DUTY_W-1:0]   duty;
  logic                         duty_written;
  logic [lfd_pkg::LEVEL_W-1:0]  level;
  logic                         lamp_on;

  modport source (output valid, duty, duty_written, level, lamp_on, input ready);
  modport sink   (input valid, duty, duty_written, level, lamp_on, output ready);
endinterface

`default_nettype wire

>>> rtl/led_fade_ramp_exp_dimmer.sv
// LED fade ramp dimmer with exponential brightness.
// Command items enter on cmd (kind, target_level); every command gives one
// result item on res (duty, duty_written, level, lamp_on). Kinds: tick,
// set target, turn on, turn off, set now; other kinds echo the state.
// Ramp state is updated in the cycle the item is accepted, so a new item
// may be accepted every cycle while res does not stall. The result leaves
// through a six-register pipeline (state, multiply, reciprocal divide,
// add/clamp, digit split, table lookup and shift). Throughput is one item
// per cycle while results are taken without a stall on res.
// The whole pipeline advances together: when res is stalled with a valid
// result, cmd.ready drops and every stage holds.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 ramp
// step, 1 min output level, 2 max output level; index 3 is ignored). Write
// only while no item is in flight.
// Reset (rst, synchronous) empties the pipeline, sets level and target to
// 0, the remembered target to 700, the lamp off, the last duty to 0 and
// the registers to step 10, min 0, max 1000.
`timescale 1ns / 1ps
`default_nettype none

module led_fade_ramp_exp_dimmer (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [lfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lfd_pkg::LEVEL_W-1:0]   cfg_data,
  lfd_cmd_if.sink                            cmd,
  lfd_res_if.source                          res
);
  import lfd_pkg::*;

  logic [LEVEL_W-1:0] ramp_step;
  logic [LEVEL_W-1:0] min_level;
  logic [LEVEL_W-1:0] max_level;
  logic               en;
  logic               accept;
  logic               s1_valid;
  item_t              s1_item;
  logic               s4_valid;
  map_t               s4_map;
  logic               out_valid;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_step <= RAMP_STEP_RESET;
      min_level <= MIN_LEVEL_RESET;
      max_level <= MAX_LEVEL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RAMP_STEP: ramp_step <= cfg_data;
        CFG_MIN_LEVEL: min_level <= cfg_data;
        CFG_MAX_LEVEL: max_level <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline advance
  assign en        = !out_valid || res.ready;
  assign accept    = cmd.valid && en;
  assign cmd.ready = en;
  assign res.valid = out_valid;

  lfd_state u_state (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .accept       (accept),
    .kind         (cmd.kind),
    .target_level (cmd.target_level),
    .ramp_step    (ramp_step),
    .out_valid    (s1_valid),
    .out_item     (s1_item)
  );

  lfd_map u_map (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s1_valid),
    .in_item   (s1_item),
    .min_level (min_level),
    .max_level (max_level),
    .out_valid (s4_valid),
    .out_map   (s4_map)
  );

  lfd_exp u_exp (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (s4_valid),
    .in_map       (s4_map),
    .out_valid    (out_valid),
    .duty         (res.duty),
    .duty_written (res.duty_written),
    .level        (res.level),
    .lamp_on      (res.lamp_on)
  );

  // The ramp level never leaves 0..FULL_SCALE
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.level <= LEVEL_W'(FULL_SCALE))
    else $error("level above full scale");

  // A freshly written duty is in 1..1024
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.duty_written) |->
      (res.duty != '0 && res.duty <= DUTY_W'(1024)))
    else $error("written duty out of range");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !res.valid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire

>>> rtl/lfd_state.sv
// Command decode and ramp state: updates level, target, remembered target
// and on flag for every accepted item, and registers the item status.
// Depends on lfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfd_state (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic                        accept,
  input  wire logic [lfd_pkg::KIND_W-1:0]  kind,
  input  wire logic [lfd_pkg::LEVEL_W-1:0] target_level,
  input  wire logic [lfd_pkg::LEVEL_W-1:0] ramp_step,
  output logic                             out_valid,
  output lfd_pkg::item_t                   out_item
);
  import lfd_pkg::*;

  localparam logic [LEVEL_W-1:0] FULL = LEVEL_W'(FULL_SCALE);

  logic [LEVEL_W-1:0] ramp_level, ramp_level_next;
  logic [LEVEL_W-1:0] target, target_next;
  logic [LEVEL_W-1:0] remembered, remembered_next;
  logic               on_flag, on_flag_next;
  logic [LEVEL_W:0]   step_sum;
  logic [LEVEL_W-1:0] gap;
  logic [LEVEL_W-1:0] set_t;
  logic               set_en;
  logic               written;
  logic               is_tick;

  // Next state for the current command
  always_comb begin
    ramp_level_next = ramp_level;
    target_next     = target;
    remembered_next = remembered;
    on_flag_next    = on_flag;
    set_t           = '0;
    set_en          = 1'b0;
    written         = 1'b0;
    is_tick         = 1'b0;
    step_sum        = {1'b0, ramp_level} + {1'b0, ramp_step};
    gap             = ramp_level - target;

    unique case (kind)
      KIND_TICK: begin
        written = 1'b1;
        is_tick = 1'b1;
        if (target > ramp_level && ramp_level < FULL && on_flag) begin
          // fade up, stopping at the target and at full scale
          if (step_sum > {1'b0, target}) begin
            ramp_level_next = target;
          end else if (step_sum > {1'b0, FULL}) begin
            ramp_level_next = FULL;
          end else begin
            ramp_level_next = step_sum[LEVEL_W-1:0];
          end
        end else if (target < ramp_level && ramp_level != '0) begin
          // fade down, stopping at the target
          if (ramp_step >= gap) begin
            ramp_level_next = target;
          end else begin
            ramp_level_next = ramp_level - ramp_step;
          end
        end
      end
      KIND_SET: begin
        set_en = 1'b1;
        set_t  = (target_level > FULL) ? FULL : target_level;
      end
      KIND_ON: begin
        set_en = 1'b1;
        set_t  = remembered;
      end
      KIND_OFF: begin
        set_en = 1'b1;
        set_t  = '0;
      end
      KIND_NOW: begin
        written         = 1'b1;
        ramp_level_next = target;
      end
      default: ;
    endcase

    // New target: nonzero turns the lamp on and is remembered
    if (set_en) begin
      target_next = set_t;
      if (set_t != '0) begin
        on_flag_next    = 1'b1;
        remembered_next = set_t;
      end else begin
        on_flag_next = 1'b0;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_level <= '0;
      target     <= '0;
      remembered <= REMEMBERED_RESET;
      on_flag    <= 1'b0;
    end else if (accept) begin
      ramp_level <= ramp_level_next;
      target     <= target_next;
      remembered <= remembered_next;
      on_flag    <= on_flag_next;
    end
  end

  // Item status register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item.written <= written;
      out_item.is_tick <= is_tick;
      out_item.level   <= ramp_level_next;
      out_item.lamp_on <= on_flag_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/lfd_map.sv
// Linear map of the ramp level onto min..max: multiply, divide by full
// scale through a reciprocal multiply, then add and clamp. Three stages.
// Depends on lfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfd_map (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire lfd_pkg::item_t              in_item,
  input  wire logic [lfd_pkg::LEVEL_W-1:0] min_level,
  input  wire logic [lfd_pkg::LEVEL_W-1:0] max_level,
  output logic                             out_valid,
  output lfd_pkg::map_t                    out_map
);
  import lfd_pkg::*;

  localparam int unsigned MAG_W  = 2 * LEVEL_W;
  localparam int unsigned PROD_W = MAG_W + DIV_RECIP_W;
  localparam logic [LEVEL_W+1:0] VMAX = (LEVEL_W + 2)'(EXP_MAX_LEVEL);

  logic               s2_valid, s3_valid;
  item_t              s2_item, s3_item;
  logic               s2_neg, s3_neg;
  logic [MAG_W-1:0]   s2_mag;
  logic [LEVEL_W-1:0] s3_quot;
  logic               neg;
  logic [LEVEL_W-1:0] dmag;
  logic [PROD_W-1:0]  prod;
  logic [LEVEL_W+1:0] vsum;
  logic [LEVEL_W-1:0] v;

  // Stage 2: level times |max - min|
  always_comb begin
    neg  = max_level < min_level;
    dmag = neg ? (min_level - max_level) : (max_level - min_level);
  end

  // Stage 3: floor(mag / FULL_SCALE)
  assign prod = PROD_W'(s2_mag) * PROD_W'(DIV_RECIP);

  // Stage 4: min plus or minus the quotient, clamped; non-tick items pass level
  always_comb begin
    if (s3_neg) begin
      vsum = {2'b00, min_level} - {2'b00, s3_quot};
    end else begin
      vsum = {2'b00, min_level} + {2'b00, s3_quot};
    end
    if (!s3_item.is_tick) begin
      v = s3_item.level;
    end else if (vsum[LEVEL_W+1]) begin
      v = '0;
    end else if (vsum > VMAX) begin
      v = VMAX[LEVEL_W-1:0];
    end else begin
      v = vsum[LEVEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s2_valid  <= in_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_item      <= in_item;
      s2_neg       <= neg;
      s2_mag       <= MAG_W'(in_item.level) * MAG_W'(dmag);
      s3_item      <= s2_item;
      s3_neg       <= s2_neg;
      s3_quot      <= prod[DIV_SHIFT +: LEVEL_W];
      out_map.item <= s3_item;
      out_map.v    <= v;
    end
  end

endmodule

`default_nettype wire

>>> rtl/lfd_exp.sv
// Exponential duty 2^(v/100): split v into hundreds and remainder, then
// table lookup and shift into the result register. Holds the last duty.
// Depends on lfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfd_exp (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire lfd_pkg::map_t               in_map,
  output logic                             out_valid,
  output logic [lfd_pkg::DUTY_W-1:0]       duty,
  output logic                             duty_written,
  output logic [lfd_pkg::LEVEL_W-1:0]      level,
  output logic                             lamp_on
);
  import lfd_pkg::*;

  localparam int unsigned DEC_W  = LEVEL_W + 6;
  localparam int unsigned Q_W    = 4;
  localparam int unsigned R_W    = 7;
  localparam int unsigned SHF_W  = 31 + DUTY_W - 1;

  logic               s5_valid;
  item_t              s5_item;
  logic [Q_W-1:0]     s5_q;
  logic [R_W-1:0]     s5_r;
  logic [DEC_W-1:0]   dec;
  logic [Q_W-1:0]     q;
  logic [LEVEL_W-1:0] r_full;
  logic [30:0]        p;
  logic [SHF_W-1:0]   shifted;
  logic [DUTY_W-1:0]  new_duty;
  logic [DUTY_W-1:0]  last_duty;

  // Stage 5: v = 100 q + r
  always_comb begin
    dec    = DEC_W'(in_map.v) * DEC_W'(DEC_MUL);
    q      = dec[DEC_SHIFT +: Q_W];
    r_full = in_map.v - LEVEL_W'(q) * LEVEL_W'(EXP_STEPS);
  end

  // Stage 6: duty = (p << q) >> 30
  always_comb begin
    p        = EXP_TAB[s5_r];
    shifted  = SHF_W'(p) << s5_q;
    new_duty = shifted[SHF_W-1 -: DUTY_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid  <= 1'b0;
      out_valid <= 1'b0;
      last_duty <= '0;
    end else if (en) begin
      s5_valid  <= in_valid;
      out_valid <= s5_valid;
      if (s5_valid && s5_item.written) begin
        last_duty <= new_duty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_item      <= in_map.item;
      s5_q         <= q;
      s5_r         <= r_full[R_W-1:0];
      duty         <= s5_item.written ? new_duty : last_duty;
      duty_written <= s5_item.written;
      level        <= s5_item.level;
      lamp_on      <= s5_item.lamp_on;
    end
  end

endmodule

`default_nettype wire

>>> sim/lfd_dimmer_checker.sv
// Checker for the LED fade ramp dimmer: watches the config port and both
// channels, predicts each result item and compares it field by field.
// Depends on lfd_pkg and the lfd_cmd_if / lfd_res_if interfaces.
`timescale 1ns / 1ps

module lfd_dimmer_checker
  import lfd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEVEL_W-1:0]   cfg_data,
  lfd_cmd_if                   cmd,
  lfd_res_if                   res,
  output int                   mismatches,
  output int                   pending
);

  localparam int     FULL      = FULL_SCALE;
  localparam longint SCALE     = 1000;
  localparam int     CENT      = 100;
  localparam longint ONE_Q30   = 64'd1073741824;
  // 2^(1/100) in Q30 and the rounding half for each step
  localparam longint CENT_STEP = 64'd1081210289;
  localparam longint HALF_Q30  = 64'd536870912;

  typedef struct packed {
    logic [DUTY_W-1:0]  duty;
    logic               duty_written;
    logic [LEVEL_W-1:0] level;
    logic               lamp_on;
  } dimmer_res_t;

  // Predicted lamp state and register copies
  int lvl, tgt, saved_tgt, duty_last;
  int step_cfg, lo_cfg, hi_cfg;
  logic lamp;
  int errs;
  dimmer_res_t awaited_res [$];

  // duty = floor(2^(v/100)) built from rounded Q30 steps
  function automatic logic [DUTY_W-1:0] exp_duty(input longint v);
    longint unsigned p;
    int q, r, i;
    if (v < 0) v = 0;
    if (v > SCALE) v = SCALE;
    q = int'(v) / CENT;
    r = int'(v) % CENT;
    p = ONE_Q30;
    for (i = 0; i < r; i++) p = (p * CENT_STEP + HALF_Q30) >> 30;
    return DUTY_W'((p << q) >> 30);
  endfunction

  function automatic void retarget(input int t);
    if (t > FULL) t = FULL;
    tgt = t;
    if (t >= 1) begin
      lamp = 1'b1;
      saved_tgt = t;
    end else begin
      lamp = 1'b0;
    end
  endfunction

  // Applies one command to the predicted state, returns the result item
  function automatic dimmer_res_t advance_dimmer(input logic [KIND_W-1:0] kind,
                                                 input logic [LEVEL_W-1:0] tl);
    dimmer_res_t r;
    int nl;
    longint span, v;
    r.duty_written = 1'b0;
    case (kind)
      KIND_TICK: begin
        // step toward the target, never past it or full scale
        if (tgt > lvl && lvl < FULL && lamp) begin
          nl = lvl + step_cfg;
          if (nl > tgt) nl = tgt;
          if (nl > FULL) nl = FULL;
          lvl = nl;
        end else if (tgt < lvl) begin
          lvl = (step_cfg >= lvl - tgt) ? tgt : lvl - step_cfg;
        end
        span = longint'(hi_cfg) - longint'(lo_cfg);
        v = longint'(lo_cfg) + (longint'(lvl) * span) / SCALE;
        duty_last = exp_duty(v);
        r.duty_written = 1'b1;
      end
      KIND_SET: retarget(tl);
      KIND_ON:  retarget(saved_tgt);
      KIND_OFF: retarget(0);
      KIND_NOW: begin
        lvl = tgt;
        duty_last = exp_duty(lvl);
        r.duty_written = 1'b1;
      end
      default: ;
    endcase
    r.duty    = DUTY_W'(duty_last);
    r.level   = LEVEL_W'(lvl);
    r.lamp_on = lamp;
    return r;
  endfunction

  always @(posedge clk) begin
    dimmer_res_t want;
    if (rst) begin
      lvl = 0;
      tgt = 0;
      saved_tgt = REMEMBERED_RESET;
      lamp = 1'b0;
      duty_last = 0;
      step_cfg = RAMP_STEP_RESET;
      lo_cfg = MIN_LEVEL_RESET;
      hi_cfg = MAX_LEVEL_RESET;
      awaited_res.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_RAMP_STEP: step_cfg = cfg_data;
          CFG_MIN_LEVEL: lo_cfg = cfg_data;
          CFG_MAX_LEVEL: hi_cfg = cfg_data;
          default: ;
        endcase
      end

      // result side: compare with the oldest prediction
      if (res.valid && res.ready) begin
        if (awaited_res.size() == 0) begin
          errs++;
          $display("%0t: unexpected result item: duty %0d written %0d level %0d on %0d",
                   $time, res.duty, res.duty_written, res.level, res.lamp_on);
        end else begin
          want = awaited_res.pop_front();
          if (res.duty !== want.duty) begin
            errs++;
            $display("%0t: duty mismatch: expected %0d, actual %0d",
                     $time, want.duty, res.duty);
          end
          if (res.duty_written !== want.duty_written) begin
            errs++;
            $display("%0t: duty_written mismatch: expected %0d, actual %0d",
                     $time, want.duty_written, res.duty_written);
          end
          if (res.level !== want.level) begin
            errs++;
            $display("%0t: level mismatch: expected %0d, actual %0d",
                     $time, want.level, res.level);
          end
          if (res.lamp_on !== want.lamp_on) begin
            errs++;
            $display("%0t: lamp_on mismatch: expected %0d, actual %0d",
                     $time, want.lamp_on, res.lamp_on);
          end
        end
      end

      // command side: predict
      if (cmd.valid && cmd.ready)
        awaited_res.push_back(advance_dimmer(cmd.kind, cmd.target_level));
    end
    mismatches <= errs;
    pending <= awaited_res.size();
  end

endmodule

>>> sim/led_fade_ramp_exp_dimmer_tb.sv
// Testbench top for the LED fade ramp dimmer: clock, reset, config writes,
// command stimulus with random gaps and result stalls, watchdog, verdict.
// Depends on lfd_pkg, the channel interfaces, the block and the checker.
`timescale 1ns / 1ps

module led_fade_ramp_exp_dimmer_tb;
  import lfd_pkg::*;

  localparam logic [KIND_W-1:0]    KIND_UNUSED_LO  = 3'd5;
  localparam logic [KIND_W-1:0]    KIND_UNUSED_MID = 3'd6;
  localparam logic [KIND_W-1:0]    KIND_UNUSED_HI  = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED     = 2'd3;
  localparam int LEVEL_MAX   = (1 << LEVEL_W) - 1;
  localparam int MAX_WAIT    = 13;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 12;
  localparam int PHASES = 7;
  localparam int PHASE_ITEMS = 170;
  localparam int N_DIRECTED = 25;

  logic clk, rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LEVEL_W-1:0]   cfg_data;
  int mismatches, pending;
  int stuck;
  bit quiet;

  lfd_cmd_if cmd();
  lfd_res_if res();

  led_fade_ramp_exp_dimmer i_dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .cmd(cmd), .res(res)
  );

  lfd_dimmer_checker i_checker (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .cmd(cmd), .res(res),
    .mismatches(mismatches), .pending(pending)
  );

  // Directed opening: lamp off, restore, saturation, full scale, fade down,
  // small remembered target, bit patterns and the unused kinds
  logic [KIND_W-1:0] dir_kind [N_DIRECTED] = '{
    KIND_TICK, KIND_NOW, KIND_ON, KIND_TICK, KIND_TICK,
    KIND_NOW, KIND_SET, KIND_TICK, KIND_NOW, KIND_TICK,
    KIND_SET, KIND_TICK, KIND_OFF, KIND_ON, KIND_SET,
    KIND_TICK, KIND_OFF, KIND_ON, KIND_NOW, KIND_SET,
    KIND_SET, KIND_UNUSED_LO, KIND_UNUSED_MID, KIND_UNUSED_HI, KIND_TICK
  };
  logic [LEVEL_W-1:0] dir_target [N_DIRECTED] = '{
    10'd0, 10'd0, 10'd0, 10'd0, 10'd0,
    10'd0, 10'd1023, 10'd0, 10'd0, 10'd0,
    10'd0, 10'd0, 10'd0, 10'd0, 10'd1,
    10'd0, 10'd0, 10'd0, 10'd0, 10'h2AA,
    10'h155, 10'h3FF, 10'd0, 10'h3FF, 10'd0
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Target values weighted toward the edges of the range
  function automatic logic [LEVEL_W-1:0] pick_target();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return LEVEL_W'(FULL_SCALE);
      2: return LEVEL_W'($urandom_range(FULL_SCALE + 1, LEVEL_MAX));
      3: return LEVEL_W'($urandom_range(1, 20));
      default: return LEVEL_W'($urandom_range(0, LEVEL_MAX));
    endcase
  endfunction

  // One command item: optional gap, then hold valid until accepted
  task automatic send_cmd(input logic [KIND_W-1:0] kind,
                          input logic [LEVEL_W-1:0] tl);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd.valid <= 1'b1;
    cmd.kind <= kind;
    cmd.target_level <= tl;
    do @(posedge clk); while (!cmd.ready);
  endtask

  // Stop sending and wait for every predicted result to come out
  task automatic settle();
    cmd.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_regs(input int step, input int lo, input int hi,
                            input bit touch_unused);
    cfg_we <= 1'b1;
    cfg_index <= CFG_RAMP_STEP;
    cfg_data <= LEVEL_W'(step);
    @(posedge clk);
    cfg_index <= CFG_MIN_LEVEL;
    cfg_data <= LEVEL_W'(lo);
    @(posedge clk);
    cfg_index <= CFG_MAX_LEVEL;
    cfg_data <= LEVEL_W'(hi);
    @(posedge clk);
    if (touch_unused) begin
      cfg_index <= CFG_UNUSED;
      cfg_data <= LEVEL_W'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Mostly fades (new target then a run of ticks), plus loose commands
  task automatic run_random(input int n);
    int sent, ticks, pick;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 39) == 0) quiet = !quiet;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        case ($urandom_range(0, 2))
          0: send_cmd(KIND_SET, pick_target());
          1: send_cmd(KIND_ON, LEVEL_W'($urandom));
          default: send_cmd(KIND_OFF, LEVEL_W'($urandom));
        endcase
        ticks = $urandom_range(1, 16);
        repeat (ticks) send_cmd(KIND_TICK, LEVEL_W'($urandom));
        sent += ticks + 1;
      end else if (pick < 92) begin
        send_cmd(KIND_W'($urandom_range(KIND_TICK, KIND_NOW)), pick_target());
        sent++;
      end else begin
        send_cmd(KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI)),
                 LEVEL_W'($urandom));
        sent++;
      end
    end
  endtask

  // Result side: random stall before each item, with quiet stretches
  initial begin
    int stall;
    res.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        res.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res.ready <= 1'b1;
      do @(posedge clk); while (!(res.valid && res.ready));
    end
  end

  // Watchdog: too long without any item moving
  always @(posedge clk) begin
    if (rst || (cmd.valid && cmd.ready) || (res.valid && res.ready)) begin
      stuck <= 0;
    end else if (stuck == STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  // Main stimulus
  initial begin
    int step, lo, hi;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_RAMP_STEP;
    cfg_data <= '0;
    cmd.valid <= 1'b0;
    cmd.kind <= KIND_TICK;
    cmd.target_level <= '0;
    quiet = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed part at reset register values
    for (int i = 0; i < N_DIRECTED; i++) send_cmd(dir_kind[i], dir_target[i]);
    settle();

    // register settings, extremes first, then random ones, then a full-range one
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin step = 1;    lo = 0;    hi = FULL_SCALE; end
        1: begin step = FULL_SCALE; lo = FULL_SCALE; hi = 0; end
        2: begin step = 0;    lo = 500;  hi = 500; end
        3: begin step = 3;    lo = 0;    hi = 0; end
        4, 5: begin
          step = $urandom_range(1, FULL_SCALE);
          lo = $urandom_range(0, FULL_SCALE);
          hi = $urandom_range(0, FULL_SCALE);
        end
        default: begin step = FULL_SCALE; lo = 0; hi = FULL_SCALE; end
      endcase
      write_regs(step, lo, hi, ph == 2);
      run_random(PHASE_ITEMS);
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
